### rtl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue checker
// Each macro is a clocked implication with synchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  // Command kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_REMOVE_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_INSERT_FULL  = 2'd2;

  // Order modes
  localparam logic MODE_LARGEST_FIRST  = 1'b0;
  localparam logic MODE_SMALLEST_FIRST = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] taken_value;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic [1:0]         status;
  } spq_out_t;

  // Value travelling down the cell row during an insert.
  // shift: the value was displaced and must go into the next cell unconditionally.
  typedef struct packed {
    logic               active;
    logic               shift;
    logic signed [31:0] value;
  } spq_carry_t;

  // Landing report of one cell.
  typedef struct packed {
    logic hit;     // travelling value lands in this empty cell
    logic direct;  // it is the inserted value itself (not a displaced one)
  } spq_land_t;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a value, takes part in the insert wave
// and in the left shift of a removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               order_mode,
  input  spq_pkg::spq_carry_t carry_in,
  input  logic               shift_left,
  input  logic               right_valid,
  input  logic signed [31:0] right_value,
  output logic signed [31:0] value,
  output logic               valid,
  output spq_pkg::spq_carry_t carry_out,
  output spq_pkg::spq_land_t  land
);
  import spq_pkg::*;

  logic               beats;
  logic               take;
  logic               carry_act;
  logic               carry_shift;
  logic signed [31:0] carry_val;

  // Stored value has priority over the travelling one only if strictly better; on a tie the travelling value wins.
  assign beats = (order_mode == MODE_SMALLEST_FIRST) ? (value < carry_in.value)
                                                     : (value > carry_in.value);

  // Take the travelling value: empty cell, forced shift, or it wins here.
  assign take = carry_in.active && (!valid || carry_in.shift || !beats);

  assign land.hit    = carry_in.active && !valid;
  assign land.direct = carry_in.active && !valid && !carry_in.shift;

  assign carry_out = '{active: carry_act, shift: carry_shift, value: carry_val};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      carry_act <= 1'b0;
    end else begin
      carry_act <= carry_in.active && valid;
      if (shift_left) begin
        valid <= right_valid;
      end else if (carry_in.active) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_left) begin
      value <= right_value;
    end else if (take) begin
      value <= carry_in.value;
    end
    // Pass the loser on: the displaced stored value, or the incoming one.
    if (take) begin
      carry_shift <= 1'b1;
      carry_val   <= value;
    end else begin
      carry_shift <= 1'b0;
      carry_val   <= carry_in.value;
    end
  end

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted list priority queue built as a row of DEPTH cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (cmd) is taken at a clock edge with start high
//   and busy low. cmd.kind selects insert or remove of the head.
//   Result channel: done is high for exactly one cycle with the result on
//   result; it cannot be held off, so capture it in that cycle.
//   Config channel: cfg_data (order mode) is written when cfg_valid and
//   cfg_ready are both high; cfg_ready is high while the queue is idle.
// Operation:
//   An insert walks down the cell row one cell per cycle until it reaches
//   the first empty cell; the queue then passes through the report state,
//   raises done and returns to idle before the next item can be taken.
//   A remove shifts the whole row left at the accepting edge and goes
//   straight to the report state, which raises done and returns to idle.
//   Error cases (insert on full, remove on empty) take that same short path.
// Reset:
//   rst (synchronous) empties the queue and selects largest-first order.
//   Cell contents are not cleared; only valid flags and the count are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  cmd,
  output logic              done,
  output spq_pkg::spq_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import spq_pkg::*;

  localparam int COUNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_REPORT = 2'd2;

  logic [1:0]         state;
  logic [COUNT_W-1:0] count;
  logic               order_mode;

  // Insert wave entry register feeding cell 0
  logic               entry_act;
  logic signed [31:0] entry_val;

  // Per-step bookkeeping
  logic signed [31:0] tail;
  logic signed [31:0] taken;
  logic [1:0]         status;

  // Cell row wiring
  spq_carry_t         carry [DEPTH+1];
  logic signed [31:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_valid;
  logic [DEPTH-1:0]   hit_vec;
  logic [DEPTH-1:0]   direct_vec;

  logic accept;
  logic is_full;
  logic is_zero;
  logic do_remove;
  logic hit_any;
  logic direct_any;

  assign accept     = start && !busy;
  assign busy       = (state != S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign is_full    = (count == COUNT_W'(DEPTH));
  assign is_zero    = (count == '0);
  assign do_remove  = accept && (cmd.kind == KIND_REMOVE) && !is_zero;
  assign hit_any    = |hit_vec;
  assign direct_any = |direct_vec;

  assign carry[0] = '{active: entry_act, shift: 1'b0, value: entry_val};

  // Row of cells; cell 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_land_t          land;
    logic               nb_valid;
    logic signed [31:0] nb_value;

    if (i == DEPTH - 1) begin : g_last
      assign nb_valid = 1'b0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .order_mode (order_mode),
      .carry_in   (carry[i]),
      .shift_left (do_remove),
      .right_valid(nb_valid),
      .right_value(nb_value),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .carry_out  (carry[i+1]),
      .land       (land)
    );

    assign hit_vec[i]    = land.hit;
    assign direct_vec[i] = land.direct;
  end

  // Control: state, count, mode, wave entry, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      order_mode <= MODE_LARGEST_FIRST;
      entry_act  <= 1'b0;
      done       <= 1'b0;
    end else begin
      entry_act <= 1'b0;
      done      <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        order_mode <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.kind == KIND_INSERT && !is_full) begin
              // Launch the wave; count is updated at once, before it lands.
              entry_act <= 1'b1;
              count     <= count + 1'b1;
              state     <= S_WALK;
            end else begin
              if (do_remove) begin
                count <= count - 1'b1;
              end
              state <= S_REPORT;
            end
          end
        end
        S_WALK: begin
          // Hold until the travelling value lands in the first empty cell.
          if (hit_any) begin
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: step bookkeeping and the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_val <= cmd.value;
      taken     <= do_remove ? cell_value[0] : 32'sd0;
      if (cmd.kind == KIND_INSERT) begin
        status <= is_full ? STATUS_INSERT_FULL : STATUS_OK;
      end else begin
        status <= is_zero ? STATUS_REMOVE_EMPTY : STATUS_OK;
      end
    end
    // Tail changes only when the inserted value itself ends up last;
    // a removal leaves the last value in place.
    if (state == S_WALK && direct_any) begin
      tail <= entry_val;
    end
    if (state == S_REPORT) begin
      result.taken_value <= taken;
      result.head_value  <= is_zero ? 32'sd0 : cell_value[0];
      result.tail_value  <= is_zero ? 32'sd0 : tail;
      result.entry_count <= 5'(count);
      result.is_empty    <= is_zero;
      result.status      <= status;
    end
  end

endmodule

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sorted_priority_queue_assert.svh"

module spq_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input spq_pkg::spq_out_t result,
  input logic              cfg_ready
);
  import spq_pkg::*;

  `SPQ_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done, "accepted item did not make the queue busy")
  `SPQ_ASSERT_IMP(a_done_idle, done, !busy && cfg_ready, "result strobe while busy")
  `SPQ_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `SPQ_ASSERT_IMP(a_empty_flag, done, result.is_empty == (result.entry_count == 5'd0) && (!result.is_empty || (result.head_value == 32'sd0 && result.tail_value == 32'sd0)), "empty flag disagrees with count or head/tail")
  `SPQ_ASSERT_IMP(a_remove_empty, done && result.status == STATUS_REMOVE_EMPTY, result.is_empty && result.taken_value == 32'sd0, "remove on empty reported a value")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .result   (result),
  .cfg_ready(cfg_ready)
);
